@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the spiral matrix block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion violated");
`define ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion violated");
`define ASSERT_NEVER(label, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("assertion violated");
`else
`define ASSERT_IMPLY(label, a, c)
`define ASSERT_NEXT(label, a, c)
`define ASSERT_NEVER(label, a)
`endif
`endif

@@ rtl/spm_pkg.sv @@
// Types and constants of the spiral matrix block.
package spm_pkg;

  localparam int unsigned COUNT_BITS = 5;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned INDEX_BITS = 4;

  localparam logic [COUNT_BITS-1:0] ROW_COUNT_RESET = 5'd4;
  localparam logic [COUNT_BITS-1:0] COL_COUNT_RESET = 5'd4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COL_COUNT = 2'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef enum logic [3:0] {
    HEAD_RIGHT = 4'b0001,
    HEAD_DOWN  = 4'b0010,
    HEAD_LEFT  = 4'b0100,
    HEAD_UP    = 4'b1000
  } heading_t;

  typedef struct packed {
    logic                         cmd;
    logic signed [FIELD_BITS-1:0] load_value;
  } req_item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] element;
    logic [INDEX_BITS-1:0]        row_index;
    logic [INDEX_BITS-1:0]        col_index;
    logic                         last_of_spiral;
  } rsp_item_t;

  typedef struct packed {
    logic restart;
    logic step;
  } walk_ctrl_t;

endpackage

@@ rtl/spm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module spm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/spm_walker.sv @@
// Spiral walker: bounds, heading and position of the next element to emit.
module spm_walker #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  spm_pkg::walk_ctrl_t                           ctrl,
  input  logic [$clog2(MAX_ROWS+1)-1:0]                 rows_used,
  input  logic [$clog2(MAX_COLS+1)-1:0]                 cols_used,
  output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] row,
  output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] col,
  output logic                                          last
);

  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW = $clog2(MAX_COLS + 1);
  localparam int unsigned SRW = RCW + 1;
  localparam int unsigned SCW = CCW + 1;
  localparam int unsigned RIW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CIW = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam logic signed [SRW-1:0] R_ONE = SRW'(1);
  localparam logic signed [SCW-1:0] C_ONE = SCW'(1);

  logic signed [SRW-1:0] top_bound, bottom_bound, walk_row;
  logic signed [SCW-1:0] left_bound, right_bound, walk_col;
  spm_pkg::heading_t     heading;

  logic signed [SRW-1:0] top_next, bottom_next, row_next;
  logic signed [SCW-1:0] left_next, right_next, col_next;
  spm_pkg::heading_t     heading_next;
  logic                  more;

  always_comb begin
    logic go_left;
    logic go_up;
    logic go_ring;
    top_next     = top_bound;
    bottom_next  = bottom_bound;
    left_next    = left_bound;
    right_next   = right_bound;
    row_next     = walk_row;
    col_next     = walk_col;
    heading_next = heading;
    more         = 1'b1;
    go_left      = 1'b0;
    go_up        = 1'b0;
    go_ring      = 1'b0;

    unique case (heading)
      spm_pkg::HEAD_RIGHT: begin
        if (walk_col < right_bound) begin
          col_next = walk_col + C_ONE;
        end else begin
          top_next = top_bound + R_ONE;
          if (top_next <= bottom_next) begin
            heading_next = spm_pkg::HEAD_DOWN;
            row_next     = top_next;
            col_next     = right_next;
          end else begin
            more = 1'b0;
          end
        end
      end
      spm_pkg::HEAD_DOWN: begin
        if (walk_row < bottom_bound) begin
          row_next = walk_row + R_ONE;
        end else begin
          right_next = right_bound - C_ONE;
          go_left    = 1'b1;
        end
      end
      spm_pkg::HEAD_LEFT: begin
        if (walk_col > left_bound) begin
          col_next = walk_col - C_ONE;
        end else begin
          bottom_next = bottom_bound - R_ONE;
          go_up       = 1'b1;
        end
      end
      spm_pkg::HEAD_UP: begin
        if (walk_row > top_bound) begin
          row_next = walk_row - R_ONE;
        end else begin
          left_next = left_bound + C_ONE;
          go_ring   = 1'b1;
        end
      end
      default: begin
        more = 1'b0;
      end
    endcase

    if (go_left) begin
      if (top_next <= bottom_next && left_next <= right_next) begin
        heading_next = spm_pkg::HEAD_LEFT;
        row_next     = bottom_next;
        col_next     = right_next;
      end else begin
        if (top_next <= bottom_next) begin
          bottom_next = bottom_next - R_ONE;
        end
        go_up = 1'b1;
      end
    end

    if (go_up) begin
      if (left_next <= right_next && bottom_next >= top_next) begin
        heading_next = spm_pkg::HEAD_UP;
        row_next     = bottom_next;
        col_next     = left_next;
      end else begin
        if (left_next <= right_next) begin
          left_next = left_next + C_ONE;
        end
        go_ring = 1'b1;
      end
    end

    if (go_ring) begin
      if (top_next <= bottom_next && left_next <= right_next) begin
        heading_next = spm_pkg::HEAD_RIGHT;
        row_next     = top_next;
        col_next     = left_next;
      end else begin
        more = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart || (ctrl.step && !more)) begin
      top_bound    <= '0;
      bottom_bound <= $signed({1'b0, rows_used}) - R_ONE;
      left_bound   <= '0;
      right_bound  <= $signed({1'b0, cols_used}) - C_ONE;
      heading      <= spm_pkg::HEAD_RIGHT;
      walk_row     <= '0;
      walk_col     <= '0;
    end else if (ctrl.step) begin
      top_bound    <= top_next;
      bottom_bound <= bottom_next;
      left_bound   <= left_next;
      right_bound  <= right_next;
      heading      <= heading_next;
      walk_row     <= row_next;
      walk_col     <= col_next;
    end
  end

  assign row  = RIW'($unsigned(walk_row));
  assign col  = CIW'($unsigned(walk_col));
  assign last = !more;

endmodule

@@ rtl/spiral_matrix_order.sv @@
// Top level of the spiral matrix block: store, load counter, read pipeline.
//
// The request channel (req_valid, req_stall, req) carries load and emit items.
// A load item writes load_value at the next row-major position and produces no
// result; it also restarts the spiral from the top-left corner. An emit item
// produces one result on the response channel (rsp_valid, rsp_stall, rsp):
// the element at the current spiral position, its row and column, and a flag
// on the final element, after which the spiral starts over.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// the row and column counts; a write to either count restarts the spiral and the load counter.
// It is always ready; the user must write it only while the block is idle; the block does not enforce this.
// Throughput is one item per cycle while req_stall is low. When an emit item is
// accepted, the accepting edge does the registered read of the element memory,
// and the response register is loaded from it once that register is free.
// When the receiver stalls, the response register holds its item and one more
// result waits behind it; further requests are stalled until space frees up.
// Reset clears the counts to four by four, the load counter and the walker;
// the element memory is not cleared and needs no clearing pass.
module spiral_matrix_order #(
  parameter int unsigned MAX_ROWS  = 16,
  parameter int unsigned MAX_COLS  = 16,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  spm_pkg::req_item_t                  req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output spm_pkg::rsp_item_t                  rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [spm_pkg::COUNT_BITS-1:0]      cfg_data
);

  `include "assert_macros.svh"

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned TW    = $clog2(DEPTH + 1);
  localparam int unsigned RCW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW   = $clog2(MAX_COLS + 1);
  localparam int unsigned RIW   = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CIW   = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;

  function automatic logic [6:0] clamp_count(input logic [spm_pkg::COUNT_BITS-1:0] v,
                                             input int unsigned max_count);
    logic [6:0] res;
    if (v == '0) begin
      res = 7'd1;
    end else if (32'(v) > max_count) begin
      res = 7'(max_count);
    end else begin
      res = 7'(v);
    end
    return res;
  endfunction

  logic [spm_pkg::COUNT_BITS-1:0] row_count, col_count;
  logic [spm_pkg::COUNT_BITS-1:0] row_count_next, col_count_next;
  logic [RCW-1:0]                 rows_cur, rows_new;
  logic [CCW-1:0]                 cols_cur, cols_new;
  logic [TW-1:0]                  total;
  logic                           cfg_hit;

  logic [AW-1:0]                  load_counter;
  logic [AW:0]                    load_counter_inc;

  logic                           req_fire, emit_fire, load_fire;
  spm_pkg::walk_ctrl_t            walk_ctrl;
  logic [RIW-1:0]                 walk_row;
  logic [CIW-1:0]                 walk_col;
  logic                           walk_last;
  logic [AW:0]                    rd_addr_full;
  logic [DATA_BITS-1:0]           rd_data;

  logic                           p_valid, p_advance;
  logic [RIW-1:0]                 p_row;
  logic [CIW-1:0]                 p_col;
  logic                           p_last;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == spm_pkg::REG_ROW_COUNT ||
                      cfg_index == spm_pkg::REG_COL_COUNT);

  always_comb begin
    row_count_next = row_count;
    col_count_next = col_count;
    if (rst) begin
      row_count_next = spm_pkg::ROW_COUNT_RESET;
      col_count_next = spm_pkg::COL_COUNT_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index == spm_pkg::REG_ROW_COUNT) begin
      row_count_next = cfg_data;
    end else if (cfg_valid && cfg_ready && cfg_index == spm_pkg::REG_COL_COUNT) begin
      col_count_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    row_count <= row_count_next;
    col_count <= col_count_next;
  end

  assign rows_cur = RCW'(clamp_count(row_count, MAX_ROWS));
  assign cols_cur = CCW'(clamp_count(col_count, MAX_COLS));
  assign rows_new = RCW'(clamp_count(row_count_next, MAX_ROWS));
  assign cols_new = CCW'(clamp_count(col_count_next, MAX_COLS));
  assign total    = TW'(rows_cur) * TW'(cols_cur);

  assign p_advance = p_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = p_valid && rsp_valid && rsp_stall;
  assign req_fire  = req_valid && !req_stall;
  assign emit_fire = req_fire && req.cmd == spm_pkg::CMD_EMIT;
  assign load_fire = req_fire && req.cmd == spm_pkg::CMD_LOAD;

  assign load_counter_inc = {1'b0, load_counter} + (AW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      load_counter <= '0;
    end else if (load_fire) begin
      if ((TW+AW+1)'(load_counter_inc) >= (TW+AW+1)'(total)) begin
        load_counter <= '0;
      end else begin
        load_counter <= load_counter_inc[AW-1:0];
      end
    end
  end

  assign walk_ctrl.restart = load_fire || cfg_hit;
  assign walk_ctrl.step    = emit_fire;

  spm_walker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (walk_ctrl),
    .rows_used(rows_new),
    .cols_used(cols_new),
    .row      (walk_row),
    .col      (walk_col),
    .last     (walk_last)
  );

  assign rd_addr_full = (AW+1)'(walk_row) * (AW+1)'(cols_cur) + (AW+1)'(walk_col);

  spm_ram #(
    .WIDTH(DATA_BITS),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (load_fire),
    .waddr(load_counter),
    .wdata(DATA_BITS'($unsigned(req.load_value))),
    .re   (emit_fire),
    .raddr(rd_addr_full[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (emit_fire) begin
      p_valid <= 1'b1;
    end else if (p_advance) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      p_row  <= walk_row;
      p_col  <= walk_col;
      p_last <= walk_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (p_advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_advance) begin
      rsp.element        <= spm_pkg::FIELD_BITS'(rd_data);
      rsp.row_index      <= spm_pkg::INDEX_BITS'(p_row);
      rsp.col_index      <= spm_pkg::INDEX_BITS'(p_col);
      rsp.last_of_spiral <= p_last;
    end
  end

  `ASSERT_NEXT(a_pending_kept, p_valid && !p_advance, p_valid)
  `ASSERT_NEXT(a_emit_queued, emit_fire, p_valid)
  `ASSERT_NEVER(a_walk_in_range,
    (RCW+1)'(walk_row) >= (RCW+1)'(rows_cur) || (CCW+1)'(walk_col) >= (CCW+1)'(cols_cur))
  `ASSERT_NEVER(a_load_in_range, (TW+AW)'(load_counter) >= (TW+AW)'(total))

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the spiral matrix block: directed script, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_MAX = 16;
  localparam int STORE_DEPTH = DIM_MAX * DIM_MAX;
  localparam int HOLD_CYCLES = 40;
  localparam logic [spm_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    bit                                 is_cfg;
    logic [spm_pkg::CFG_INDEX_BITS-1:0] cfg_idx;
    logic [spm_pkg::COUNT_BITS-1:0]     cfg_val;
    spm_pkg::req_item_t                 item;
    bit                                 typed;
    spm_pkg::rsp_item_t                 want;
  } script_row_t;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               req_valid = 1'b0;
  logic                               req_stall;
  spm_pkg::req_item_t                 req = '0;
  logic                               rsp_valid;
  logic                               rsp_stall = 1'b0;
  spm_pkg::rsp_item_t                 rsp;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [spm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [spm_pkg::COUNT_BITS-1:0]     cfg_data = '0;

  // Shadow of the block: counts, store, load position and the spiral walker.
  logic [spm_pkg::COUNT_BITS-1:0]        row_reg;
  logic [spm_pkg::COUNT_BITS-1:0]        col_reg;
  logic signed [spm_pkg::FIELD_BITS-1:0] element_store [STORE_DEPTH];
  bit                                    written [STORE_DEPTH];
  int                                    load_pos;
  int                                    top_b, bottom_b, left_b, right_b;
  int                                    walk_row, walk_col;
  spm_pkg::heading_t                     walk_dir;

  spm_pkg::rsp_item_t expected_rsp [$];
  script_row_t        script [$];
  int                 failures = 0;
  bit                 steady = 1'b0;
  bit                 hold_off_req = 1'b0;

  spiral_matrix_order i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("spiral_matrix_order regression: fail");
    $finish;
  end

  function automatic int clamp_dim(input logic [spm_pkg::COUNT_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  function automatic void walker_restart();
    top_b = 0;
    bottom_b = clamp_dim(row_reg) - 1;
    left_b = 0;
    right_b = clamp_dim(col_reg) - 1;
    walk_dir = spm_pkg::HEAD_RIGHT;
    walk_row = 0;
    walk_col = 0;
  endfunction

  function automatic bit next_ring();
    if (top_b <= bottom_b && left_b <= right_b) begin
      walk_dir = spm_pkg::HEAD_RIGHT;
      walk_row = top_b;
      walk_col = left_b;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit enter_up();
    if (left_b <= right_b) begin
      if (bottom_b >= top_b) begin
        walk_dir = spm_pkg::HEAD_UP;
        walk_row = bottom_b;
        walk_col = left_b;
        return 1'b1;
      end
      left_b++;
    end
    return next_ring();
  endfunction

  // Steps to the next spiral position; returns 0 after the final element.
  function automatic bit advance_walker();
    case (walk_dir)
      spm_pkg::HEAD_RIGHT: begin
        if (walk_col < right_b) begin
          walk_col++;
          return 1'b1;
        end
        top_b++;
        if (top_b <= bottom_b) begin
          walk_dir = spm_pkg::HEAD_DOWN;
          walk_row = top_b;
          walk_col = right_b;
          return 1'b1;
        end
        return 1'b0;
      end
      spm_pkg::HEAD_DOWN: begin
        if (walk_row < bottom_b) begin
          walk_row++;
          return 1'b1;
        end
        right_b--;
        if (top_b <= bottom_b) begin
          if (left_b <= right_b) begin
            walk_dir = spm_pkg::HEAD_LEFT;
            walk_row = bottom_b;
            walk_col = right_b;
            return 1'b1;
          end
          bottom_b--;
        end
        return enter_up();
      end
      spm_pkg::HEAD_LEFT: begin
        if (walk_col > left_b) begin
          walk_col--;
          return 1'b1;
        end
        bottom_b--;
        return enter_up();
      end
      default: begin
        if (walk_row > top_b) begin
          walk_row--;
          return 1'b1;
        end
        left_b++;
        return next_ring();
      end
    endcase
  endfunction

  function automatic bit spiral_step(input spm_pkg::req_item_t it,
                                     output spm_pkg::rsp_item_t res);
    int total;
    int addr;
    res = '0;
    total = clamp_dim(row_reg) * clamp_dim(col_reg);
    if (it.cmd == spm_pkg::CMD_LOAD) begin
      element_store[load_pos] = it.load_value;
      written[load_pos] = 1'b1;
      load_pos++;
      if (load_pos >= total) load_pos = 0;
      walker_restart();
      return 1'b0;
    end
    addr = walk_row * clamp_dim(col_reg) + walk_col;
    res.element = element_store[addr];
    res.row_index = 4'(walk_row);
    res.col_index = 4'(walk_col);
    res.last_of_spiral = !advance_walker();
    if (res.last_of_spiral) walker_restart();
    return 1'b1;
  endfunction

  function automatic logic signed [spm_pkg::FIELD_BITS-1:0] rand_word();
    case ($urandom_range(15))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [spm_pkg::COUNT_BITS-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return spm_pkg::COUNT_BITS'($urandom_range(31, 16));
    return spm_pkg::COUNT_BITS'($urandom_range(5, 1));
  endfunction

  function automatic script_row_t cfg_row(input logic [spm_pkg::CFG_INDEX_BITS-1:0] idx,
                                          input logic [spm_pkg::COUNT_BITS-1:0] val);
    script_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  function automatic script_row_t item_row(input logic cmd, input logic signed [31:0] v,
                                           input bit typed = 1'b0,
                                           input spm_pkg::rsp_item_t want = '0);
    script_row_t row;
    row = '{default: '0};
    row.item = '{cmd: cmd, load_value: v};
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic void add_step(input script_row_t row);
    script.insert(script.size(), row);
  endfunction

  task automatic send_item(input spm_pkg::req_item_t it, input bit typed,
                           input spm_pkg::rsp_item_t want);
    spm_pkg::rsp_item_t res;
    while (!steady && $urandom_range(99) < 7) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (spiral_step(it, res)) expected_rsp.insert(expected_rsp.size(), typed ? want : res);
  endtask

  task automatic write_register(input logic [spm_pkg::CFG_INDEX_BITS-1:0] idx,
                                input logic [spm_pkg::COUNT_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == spm_pkg::REG_ROW_COUNT || idx == spm_pkg::REG_COL_COUNT) begin
      if (idx == spm_pkg::REG_ROW_COUNT) row_reg = val;
      else col_reg = val;
      load_pos = 0;
      walker_restart();
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        rsp_stall <= !steady && ($urandom_range(99) < 7);
      end
    end
  end

  always @(posedge clk) begin
    spm_pkg::rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result: element %0d row %0d col %0d last %0b",
               rsp.element, rsp.row_index, rsp.col_index, rsp.last_of_spiral);
        failures++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.element !== want.element) begin
          $error("element: expected %0d, got %0d", want.element, rsp.element);
          failures++;
        end
        if (rsp.row_index !== want.row_index) begin
          $error("row_index: expected %0d, got %0d", want.row_index, rsp.row_index);
          failures++;
        end
        if (rsp.col_index !== want.col_index) begin
          $error("col_index: expected %0d, got %0d", want.col_index, rsp.col_index);
          failures++;
        end
        if (rsp.last_of_spiral !== want.last_of_spiral) begin
          $error("last_of_spiral: expected %0b, got %0b",
                 want.last_of_spiral, rsp.last_of_spiral);
          failures++;
        end
      end
    end
  end

  initial begin
    spm_pkg::req_item_t             it;
    int                             random_items;
    int                             phase;
    int                             total;
    int                             load_n;
    int                             emit_n;
    int                             r;
    logic [spm_pkg::COUNT_BITS-1:0] rows_val;
    logic [spm_pkg::COUNT_BITS-1:0] cols_val;

    row_reg = spm_pkg::ROW_COUNT_RESET;
    col_reg = spm_pkg::COL_COUNT_RESET;
    load_pos = 0;
    walker_restart();

    // A zero count acts as one; a load restarts the walk; unused indexes change nothing.
    add_step(cfg_row(spm_pkg::REG_ROW_COUNT, 5'd1));
    add_step(cfg_row(spm_pkg::REG_COL_COUNT, 5'd0));
    add_step(item_row(spm_pkg::CMD_LOAD, 32'sh8000_0000));
    add_step(item_row(spm_pkg::CMD_EMIT, '0, 1'b1, '{32'sh8000_0000, 4'd0, 4'd0, 1'b1}));
    add_step(item_row(spm_pkg::CMD_EMIT, '1, 1'b1, '{32'sh8000_0000, 4'd0, 4'd0, 1'b1}));
    add_step(cfg_row(spm_pkg::REG_COL_COUNT, 5'd2));
    add_step(item_row(spm_pkg::CMD_LOAD, 32'sh7FFF_FFFF));
    add_step(item_row(spm_pkg::CMD_LOAD, 32'sh0));
    add_step(item_row(spm_pkg::CMD_EMIT, '0, 1'b1, '{32'sh7FFF_FFFF, 4'd0, 4'd0, 1'b0}));
    add_step(item_row(spm_pkg::CMD_LOAD, -32'sd1));
    add_step(item_row(spm_pkg::CMD_EMIT, '0, 1'b1, '{-32'sd1, 4'd0, 4'd0, 1'b0}));
    add_step(item_row(spm_pkg::CMD_EMIT, '0, 1'b1, '{32'sh0, 4'd0, 4'd1, 1'b1}));
    add_step(cfg_row(spm_pkg::REG_ROW_COUNT, 5'd2));
    add_step(item_row(spm_pkg::CMD_LOAD, 32'sh1234_5678));
    add_step(item_row(spm_pkg::CMD_LOAD, 32'shA5A5_5A5A));
    add_step(item_row(spm_pkg::CMD_LOAD, 32'sh0F0F_F0F0));
    add_step(item_row(spm_pkg::CMD_LOAD, 32'sh5555_AAAA));
    add_step(item_row(spm_pkg::CMD_EMIT, '0));
    add_step(item_row(spm_pkg::CMD_EMIT, '0));
    add_step(cfg_row(REG_UNUSED, 5'd5));
    add_step(item_row(spm_pkg::CMD_EMIT, '0));
    add_step(item_row(spm_pkg::CMD_EMIT, '0));
    add_step(item_row(spm_pkg::CMD_EMIT, '0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_register(script[i].cfg_idx, script[i].cfg_val);
      end else begin
        send_item(script[i].item, script[i].typed, script[i].want);
      end
    end

    random_items = 0;
    for (phase = 0; phase < 3 || random_items < 400; phase++) begin
      case (phase)
        0: begin rows_val = 5'd31; cols_val = 5'd17; end
        1: begin rows_val = 5'd2; cols_val = 5'd5; end
        2: begin rows_val = 5'd0; cols_val = 5'd17; end
        default: begin
          rows_val = pick_dim();
          cols_val = pick_dim();
        end
      endcase
      settle();
      steady = (phase == 0);
      if ($urandom_range(1)) begin
        write_register(spm_pkg::REG_ROW_COUNT, rows_val);
        write_register(spm_pkg::REG_COL_COUNT, cols_val);
      end else begin
        write_register(spm_pkg::REG_COL_COUNT, cols_val);
        write_register(spm_pkg::REG_ROW_COUNT, rows_val);
      end
      if ($urandom_range(19) == 0) begin
        write_register(REG_UNUSED, spm_pkg::COUNT_BITS'($urandom_range(31)));
      end

      total = clamp_dim(row_reg) * clamp_dim(col_reg);
      r = $urandom_range(99);
      if (r < 10) load_n = $urandom_range(total, 1);
      else if (r < 15) load_n = total + $urandom_range(total, 1);
      else load_n = total;
      if (phase == 0) load_n = total;
      for (int k = 0; k < load_n; k++) begin
        it = '{cmd: spm_pkg::CMD_LOAD, load_value: rand_word()};
        send_item(it, 1'b0, '0);
        random_items++;
      end

      emit_n = $urandom_range(2 * total + 2, 1);
      if (phase == 0) emit_n = 20;
      if (phase == 1) begin
        emit_n = 2 * total + 2;
        hold_off_req = 1'b1;
      end
      if (emit_n > 100) emit_n = 100;
      for (int k = 0; k < emit_n; k++) begin
        it = '{cmd: spm_pkg::CMD_EMIT, load_value: $urandom()};
        if ($urandom_range(99) < 5 || !written[walk_row * clamp_dim(col_reg) + walk_col]) begin
          it.cmd = spm_pkg::CMD_LOAD;
          it.load_value = rand_word();
        end
        send_item(it, 1'b0, '0);
        random_items++;
      end
    end

    steady = 1'b0;
    settle();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("spiral_matrix_order regression: pass");
    end else begin
      $display("spiral_matrix_order regression: fail");
    end
    $finish;
  end

endmodule
